FILE: rtl/rcs_pkg.sv
// Shared types and constants for the ring curve smoothing block.
// No dependencies; compiled first.
package rcs_pkg;

	localparam int COORD_W = 32;
	localparam int GAIN_W  = 16;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_RD_PREV,
		ST_RD_CUR,
		ST_GET_CUR,
		ST_RD_NEXT,
		ST_GET_NEXT,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_DIV_INIT,
		ST_DIV,
		ST_AX_MUL,
		ST_AX_ERR,
		ST_AX_GAIN,
		ST_AX_SAT,
		ST_EMIT
	} state_t;

endpackage

FILE: rtl/rcs_ifs.sv
// Handshake interfaces for the ring curve smoothing block: points in,
// displacement results out, and the gain register write channel. Uses rcs_pkg.
interface rcs_pt_if;
	import rcs_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic                      last_point;
	modport source (output valid, point_x, point_y, last_point, input ready);
	modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface rcs_res_if;
	import rcs_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] disp_x;
	logic signed [COORD_W-1:0] disp_y;
	logic                      degenerate;
	logic                      overflowed;
	logic                      last_result;
	modport source (output valid, disp_x, disp_y, degenerate, overflowed, last_result,
		input ready);
	modport sink (input valid, disp_x, disp_y, degenerate, overflowed, last_result,
		output ready);
endinterface

interface rcs_cfg_if;
	import rcs_pkg::*;
	logic              valid;
	logic              ready;
	logic [GAIN_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: rtl/rcs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rcs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/ring_curve_smoothing_core.sv
// Ring curve smoothing core: top level. Uses rcs_pkg, the interfaces in
// rcs_ifs.sv and the point memory rcs_ram.
//
// The core takes a closed ring of 2-D Q16.16 points, one transaction per
// point, into a single point memory of MAX_POINTS entries; points beyond that
// are dropped and every result of the ring then carries overflowed. The point
// transaction with last_point set (stored or not) starts the smoothing pass,
// and no point is taken until the pass has handed its last result to the
// output register. Each point's target is the distance-weighted blend of its
// two neighbors and the result is smoothing_gain times the offset from the
// point to that target, saturated to 32 bits. Loading takes one point per
// cycle. The pass starts with a prologue (two memory reads plus one
// distance) and then handles each point with one memory read, two 32x32
// squares, a 32-step bit-serial square root for the distance to the next
// point (the distance to the previous point is carried over from the step
// before), a 32-step restoring divider for the blend ratio, the multiply,
// error, gain and round-and-saturate steps for each axis, and a step to
// hand the result over. A point whose neighbors both sit on it skips the
// divider and the axis steps; a point whose next neighbor sits on it skips
// only the divider. A stalled result holds the pass in its hand-over step.
// The gain register may be written whenever the core is idle; its write
// channel is always ready.
module ring_curve_smoothing_core #(
	parameter int MAX_POINTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	rcs_pt_if.sink     points,
	rcs_res_if.source  results,
	rcs_cfg_if.sink    gain_cfg
);
	import rcs_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	state_t state_q, state_d;

	logic [GAIN_W-1:0] gain_q;
	logic [CW-1:0]     cnt_q;
	logic              ovf_q;
	logic [AW-1:0]     idx_q;

	// Memory port.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	point_t        ram_wdata;
	point_t        ram_rdata;

	// Working points and distances.
	point_t      prev_q, cur_q, next_q;
	logic        pro_q;
	logic [32:0] dprev_q, dnext_q;

	// Distance datapath.
	logic [63:0] sqx_q, sqy_q;
	logic [63:0] sq_src_q;
	logic [34:0] sq_rem_q;
	logic [31:0] sq_root_q;
	logic        sq_dbl_q;
	logic [4:0]  it_q;

	// Ratio datapath.
	logic [32:0] sum_q;
	logic [32:0] dv_rem_q;
	logic [31:0] r_q;
	logic        rfull_q;
	logic        degen_q;

	// Axis datapath.
	logic        axis_q;
	logic [63:0] prod_q;
	logic [33:0] abse_q;
	logic        eneg_q;
	logic [49:0] magp_q;
	logic [31:0] dx_q, dy_q;

	// Result register.
	logic              out_valid_q;
	logic [COORD_W-1:0] o_dx_q, o_dy_q;
	logic              o_degen_q, o_ovf_q, o_last_q;

	logic in_acc, cnt_room, is_last, emit_go, ring_done;
	logic [AW-1:0] nidx;

	assign in_acc    = points.valid && points.ready;
	assign cnt_room  = cnt_q < CW'(MAX_POINTS);
	assign is_last   = (CW'(idx_q) + CW'(1)) == cnt_q;
	assign nidx      = is_last ? '0 : idx_q + AW'(1);
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || results.ready);
	assign ring_done = emit_go && is_last;

	assign points.ready   = (state_q == ST_LOAD);
	assign gain_cfg.ready = 1'b1;

	assign ram_we    = in_acc && cnt_room;
	assign ram_waddr = cnt_q[AW-1:0];
	assign ram_wdata = '{x: points.point_x, y: points.point_y};

	rcs_ram #(
		.WIDTH($bits(point_t)),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Distance operands: previous-to-current in the prologue, else current-to-next.
	logic signed [31:0] opa_x, opa_y, opb_x, opb_y;
	logic signed [32:0] ddx, ddy;
	logic [31:0]        mx, my;

	always_comb begin
		opa_x = pro_q ? prev_q.x : cur_q.x;
		opa_y = pro_q ? prev_q.y : cur_q.y;
		opb_x = pro_q ? cur_q.x : next_q.x;
		opb_y = pro_q ? cur_q.y : next_q.y;
		ddx = {opa_x[31], opa_x} - {opb_x[31], opb_x};
		ddy = {opa_y[31], opa_y} - {opb_y[31], opb_y};
		mx = ddx[32] ? 32'(-ddx) : ddx[31:0];
		my = ddy[32] ? 32'(-ddy) : ddy[31:0];
	end

	// One square root step: two radicand bits in, one root bit out.
	logic [34:0] sq_rem2, sq_trial;
	logic        sq_ge;
	logic [31:0] sq_root_n;
	logic [64:0] sq_sum;

	always_comb begin
		sq_sum    = {1'b0, sqx_q} + {1'b0, sqy_q};
		sq_rem2   = {sq_rem_q[32:0], sq_src_q[63:62]};
		sq_trial  = {1'b0, sq_root_q, 2'b01};
		sq_ge     = sq_rem2 >= sq_trial;
		sq_root_n = {sq_root_q[30:0], sq_ge};
	end

	// Halving of the distances and one restoring divide step.
	logic        halve;
	logic [31:0] ha, hb;
	logic [33:0] dv_rem2;
	logic        dv_ge;

	always_comb begin
		halve   = dprev_q[32] || dnext_q[32];
		ha      = halve ? dprev_q[32:1] : dprev_q[31:0];
		hb      = halve ? dnext_q[32:1] : dnext_q[31:0];
		dv_rem2 = {dv_rem_q, 1'b0};
		dv_ge   = dv_rem2 >= {1'b0, sum_q};
	end

	// Axis arithmetic.
	logic signed [31:0] pv, nv, cv;
	logic signed [32:0] diff;
	logic [31:0]        mdiff;
	logic [32:0]        off;
	logic [63:0]        off_sum;
	logic signed [34:0] tgt, err;
	logic [33:0]        mag;
	logic [31:0]        sat;

	always_comb begin
		pv      = axis_q ? prev_q.y : prev_q.x;
		nv      = axis_q ? next_q.y : next_q.x;
		cv      = axis_q ? cur_q.y : cur_q.x;
		diff    = {nv[31], nv} - {pv[31], pv};
		mdiff   = diff[32] ? 32'(-diff) : diff[31:0];
		off_sum = prod_q + 64'h0000_0000_8000_0000;
		off     = rfull_q ? {1'b0, mdiff} : {1'b0, off_sum[63:32]};
		tgt     = diff[32] ? ({{3{pv[31]}}, pv} - {2'b00, off})
		                   : ({{3{pv[31]}}, pv} + {2'b00, off});
		err     = tgt - {{3{cv[31]}}, cv};
		mag     = 34'((magp_q + 50'd32768) >> 16);
		if (eneg_q) begin
			sat = (mag > 34'h0_8000_0000) ? 32'h8000_0000 : 32'(-mag);
		end else begin
			sat = (mag > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		end
	end

	// Next state and memory read address.
	always_comb begin
		state_d   = state_q;
		ram_raddr = nidx;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && points.last_point) begin
					state_d = ST_RD_PREV;
				end
			end
			ST_RD_PREV: begin
				ram_raddr = AW'(cnt_q - CW'(1));
				state_d   = ST_RD_CUR;
			end
			ST_RD_CUR: begin
				ram_raddr = '0;
				state_d   = ST_GET_CUR;
			end
			ST_GET_CUR:   state_d = ST_SQ_X;
			ST_RD_NEXT:   state_d = ST_GET_NEXT;
			ST_GET_NEXT:  state_d = ST_SQ_X;
			ST_SQ_X:      state_d = ST_SQ_Y;
			ST_SQ_Y:      state_d = ST_SQRT_INIT;
			ST_SQRT_INIT: state_d = ST_SQRT;
			ST_SQRT: begin
				if (it_q == '0) begin
					state_d = pro_q ? ST_RD_NEXT : ST_DIV_INIT;
				end
			end
			ST_DIV_INIT: begin
				if ({1'b0, ha} + {1'b0, hb} == '0) begin
					state_d = ST_EMIT;
				end else if (hb == '0) begin
					state_d = ST_AX_MUL;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (it_q == '0) begin
					state_d = ST_AX_MUL;
				end
			end
			ST_AX_MUL:  state_d = ST_AX_ERR;
			ST_AX_ERR:  state_d = ST_AX_GAIN;
			ST_AX_GAIN: state_d = ST_AX_SAT;
			ST_AX_SAT:  state_d = axis_q ? ST_EMIT : ST_AX_MUL;
			ST_EMIT: begin
				if (emit_go) begin
					state_d = is_last ? ST_LOAD : ST_RD_NEXT;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (gain_cfg.valid) begin
				gain_q <= gain_cfg.data;
			end
			if (in_acc) begin
				if (cnt_room) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (ring_done) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RD_PREV: idx_q <= '0;
			ST_RD_CUR:  prev_q <= ram_rdata;
			ST_GET_CUR: begin
				cur_q <= ram_rdata;
				pro_q <= 1'b1;
			end
			ST_GET_NEXT: begin
				next_q <= ram_rdata;
				pro_q  <= 1'b0;
			end
			ST_SQ_X: sqx_q <= 64'(mx) * 64'(mx);
			ST_SQ_Y: sqy_q <= 64'(my) * 64'(my);
			ST_SQRT_INIT: begin
				// A 65-bit sum is quartered and its root doubled afterwards.
				sq_src_q  <= sq_sum[64] ? {1'b0, sq_sum[64:2]} : sq_sum[63:0];
				sq_dbl_q  <= sq_sum[64];
				sq_rem_q  <= '0;
				sq_root_q <= '0;
				it_q      <= '1;
			end
			ST_SQRT: begin
				sq_rem_q  <= sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
				sq_root_q <= sq_root_n;
				sq_src_q  <= {sq_src_q[61:0], 2'b00};
				it_q      <= it_q - 5'd1;
				if (it_q == '0) begin
					if (pro_q) begin
						dprev_q <= sq_dbl_q ? {sq_root_n, 1'b0} : {1'b0, sq_root_n};
					end else begin
						dnext_q <= sq_dbl_q ? {sq_root_n, 1'b0} : {1'b0, sq_root_n};
					end
				end
			end
			ST_DIV_INIT: begin
				sum_q    <= {1'b0, ha} + {1'b0, hb};
				dv_rem_q <= {1'b0, ha};
				rfull_q  <= (hb == '0);
				degen_q  <= ({1'b0, ha} + {1'b0, hb}) == '0;
				r_q      <= '0;
				it_q     <= '1;
				axis_q   <= 1'b0;
			end
			ST_DIV: begin
				dv_rem_q <= dv_ge ? 33'(dv_rem2 - {1'b0, sum_q}) : dv_rem2[32:0];
				r_q      <= {r_q[30:0], dv_ge};
				it_q     <= it_q - 5'd1;
			end
			ST_AX_MUL: prod_q <= 64'(mdiff) * 64'(r_q);
			ST_AX_ERR: begin
				eneg_q <= err[34];
				abse_q <= err[34] ? 34'(-err) : err[33:0];
			end
			ST_AX_GAIN: magp_q <= 50'(abse_q) * 50'(gain_q);
			ST_AX_SAT: begin
				if (axis_q) begin
					dy_q <= sat;
				end else begin
					dx_q <= sat;
				end
				axis_q <= 1'b1;
			end
			ST_EMIT: begin
				if (emit_go) begin
					o_dx_q    <= degen_q ? '0 : dx_q;
					o_dy_q    <= degen_q ? '0 : dy_q;
					o_degen_q <= degen_q;
					o_ovf_q   <= ovf_q;
					o_last_q  <= is_last;
					idx_q     <= nidx;
					prev_q    <= cur_q;
					cur_q     <= next_q;
					dprev_q   <= dnext_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign results.valid       = out_valid_q;
	assign results.disp_x      = o_dx_q;
	assign results.disp_y      = o_dy_q;
	assign results.degenerate  = o_degen_q;
	assign results.overflowed  = o_ovf_q;
	assign results.last_result = o_last_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS))
		else $error("point count exceeds ring capacity");

	a_ring_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ring_done |=> (cnt_q == '0) && !ovf_q && (state_q == ST_LOAD))
		else $error("ring state not cleared after final result");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && o_degen_q) |-> (o_dx_q == '0) && (o_dy_q == '0))
		else $error("degenerate result with nonzero displacement");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !ram_we)
		else $error("point memory written during smoothing pass");
`endif

endmodule
